/* rtl/mqrf_pkg.sv */
// Shared types and codes for the multi-queue ring FIFO.
package mqrf_pkg;

    localparam int REF_FIELD_W = 32;
    localparam int QIDX_FIELD_W = 5;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PUSH  = 2'd1;
    localparam logic [1:0] OP_POP   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    typedef struct packed {
        logic [1:0]              operation;
        logic [QIDX_FIELD_W-1:0] queue_index;
        logic [REF_FIELD_W-1:0]  message_ref;
    } t_in_item;

    typedef struct packed {
        logic [1:0]              status;
        logic [REF_FIELD_W-1:0]  popped_ref;
        logic [QIDX_FIELD_W-1:0] echoed_queue;
    } t_out_item;

    // Classified request handed from front to back (store address travels alongside).
    typedef struct packed {
        logic [1:0]              status;
        logic [QIDX_FIELD_W-1:0] echo;
        logic                    do_write;
        logic                    do_read;
        logic [REF_FIELD_W-1:0]  message_ref;
    } t_cmd;

endpackage

/* rtl/mqrf_front.sv */
// Front end: per-queue pointers, request classification and store address.
module mqrf_front #(
    parameter int QUEUE_COUNT = 16,
    parameter int QUEUE_DEPTH = 32,
    parameter int AW          = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  mqrf_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output mqrf_pkg::t_cmd    o_cmd,
    output logic [AW-1:0]     o_addr
);
    import mqrf_pkg::*;

    localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [PW-1:0] r_wp [QUEUE_COUNT];
    logic [PW-1:0] r_rp [QUEUE_COUNT];

    logic          w_q_ok;
    logic [QW-1:0] w_qsel;
    logic [PW-1:0] w_wp;
    logic [PW-1:0] w_rp;
    logic [PW-1:0] w_wp_next;
    logic [PW-1:0] w_rp_next;
    logic          w_accept;
    t_cmd          w_cmd;

    assign w_q_ok    = ({1'b0, i_item.queue_index} < 6'(QUEUE_COUNT));
    assign w_qsel    = w_q_ok ? i_item.queue_index[QW-1:0] : '0;
    assign w_wp      = r_wp[w_qsel];
    assign w_rp      = r_rp[w_qsel];
    assign w_wp_next = (w_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : w_wp + 1'b1;
    assign w_rp_next = (w_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : w_rp + 1'b1;
    assign w_accept  = i_valid && i_ready;

    always_comb begin
        w_cmd             = '0;
        w_cmd.status      = ST_BAD;
        w_cmd.message_ref = i_item.message_ref;
        if (w_q_ok) begin
            unique case (i_item.operation)
                OP_CLEAR: begin
                    w_cmd.status = ST_OK;
                    w_cmd.echo   = i_item.queue_index;
                end
                OP_PUSH: begin
                    if (w_wp_next == w_rp) begin
                        w_cmd.status = ST_FULL;
                    end else begin
                        w_cmd.status   = ST_OK;
                        w_cmd.do_write = 1'b1;
                    end
                end
                OP_POP: begin
                    if (w_rp == w_wp) begin
                        w_cmd.status = ST_EMPTY;
                    end else begin
                        w_cmd.status  = ST_OK;
                        w_cmd.do_read = 1'b1;
                    end
                end
                default: w_cmd.status = ST_BAD;
            endcase
        end
    end

    assign o_addr  = AW'(w_qsel * QUEUE_DEPTH) + AW'(w_cmd.do_write ? w_wp : w_rp);
    assign o_cmd   = w_cmd;
    assign o_valid = i_valid;
    assign o_ready = i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_COUNT; i++) begin
                r_wp[i] <= '0;
                r_rp[i] <= '0;
            end
        end else if (w_accept && w_q_ok) begin
            if (i_item.operation == OP_CLEAR) begin
                r_wp[w_qsel] <= '0;
                r_rp[w_qsel] <= '0;
            end
            if (w_cmd.do_write) begin
                r_wp[w_qsel] <= w_wp_next;
            end
            if (w_cmd.do_read) begin
                r_rp[w_qsel] <= w_rp_next;
            end
        end
    end

endmodule

/* rtl/mqrf_cmd_queue.sv */
// Two-entry queue decoupling the front end from the store back end.
module mqrf_cmd_queue #(
    parameter int AW = 9
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mqrf_pkg::t_cmd i_cmd,
    input  logic [AW-1:0]  i_addr,
    output logic           o_valid,
    input  logic           i_ready,
    output mqrf_pkg::t_cmd o_cmd,
    output logic [AW-1:0]  o_addr
);
    import mqrf_pkg::*;

    t_cmd          r_cmd  [2];
    logic [AW-1:0] r_addr [2];
    logic          r_wr_idx;
    logic          r_rd_idx;
    logic [1:0]    r_count;
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_cmd   = r_cmd[r_rd_idx];
    assign o_addr  = r_addr[r_rd_idx];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_cmd[r_wr_idx]  <= i_cmd;
            r_addr[r_wr_idx] <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= 1'b0;
            r_rd_idx <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_idx <= ~r_wr_idx;
            end
            if (w_pop) begin
                r_rd_idx <= ~r_rd_idx;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

/* rtl/mqrf_back.sv */
// Back end: shared reference store, read stage and output register.
module mqrf_back #(
    parameter int AW        = 9,
    parameter int DEPTH     = 512,
    parameter int REF_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mqrf_pkg::t_cmd     i_cmd,
    input  logic [AW-1:0]      i_addr,
    output logic               o_valid,
    input  logic               i_ready,
    output mqrf_pkg::t_out_item o_item
);
    import mqrf_pkg::*;

    logic [REF_WIDTH-1:0] r_mem [DEPTH];
    logic [REF_WIDTH-1:0] r_rd_data;
    logic [REF_WIDTH-1:0] w_wr_ref;

    logic       r_s1_valid;
    t_cmd       r_s1_cmd;
    logic       r_o_valid;
    t_out_item  r_o_item;
    logic       w_out_free;
    logic       w_s1_free;
    logic       w_take;

    assign w_out_free = !r_o_valid || i_ready;
    assign w_s1_free  = !r_s1_valid || w_out_free;
    assign w_take     = i_valid && w_s1_free;
    assign o_ready    = w_s1_free;
    assign w_wr_ref   = REF_WIDTH'(i_cmd.message_ref);

    // Store: at most one write or one read per item, read data registered.
    always_ff @(posedge i_clk) begin
        if (w_take && i_cmd.do_write) begin
            r_mem[i_addr] <= w_wr_ref;
        end
        if (w_take && i_cmd.do_read) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_cmd <= i_cmd;
        end
        if (w_out_free && r_s1_valid) begin
            r_o_item.status       <= r_s1_cmd.status;
            r_o_item.echoed_queue <= r_s1_cmd.echo;
            r_o_item.popped_ref   <= r_s1_cmd.do_read ? REF_FIELD_W'(r_rd_data) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= i_valid;
            end
            if (w_out_free) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_item  = r_o_item;

endmodule

/* rtl/multi_queue_ring_fifo.sv */
// Top level of the multi-queue ring FIFO: front end, command queue, store back end.
//
// QUEUE_COUNT circular FIFOs of QUEUE_DEPTH references share one store.
// Input channel (i_in_valid / o_in_ready / i_in_item): one request per item,
//   naming an operation (clear, push, pop) and a queue.
// Output channel (o_out_valid / i_out_ready / o_out_item): exactly one answer
//   per request, in request order: status, popped reference, echoed queue.
// A queue holds at most QUEUE_DEPTH-1 references; one slot always stays free.
// Throughput: one item per cycle while the output is not stalled. The front end
//   classifies a request and moves its queue's pointers in the cycle it is taken;
//   the back end performs at most one store access per item, so the store port
//   sets the one-item rate. An accepted request passes the command queue stage,
//   then the store read stage into the output register, before its answer is valid.
// Stalls: while i_out_ready is low the output register holds; the read stage
//   and the two-entry command queue keep filling, and o_in_ready drops only
//   once the command queue is full.
// Reset (i_rst_n low, synchronous) zeroes every pointer and drops all valid
//   flags; store contents are left as they are, since a pop only reads
//   entries pushed since the last clear or reset.
module multi_queue_ring_fifo #(
    parameter int QUEUE_COUNT = 16,
    parameter int QUEUE_DEPTH = 32,
    parameter int REF_WIDTH   = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mqrf_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mqrf_pkg::t_out_item o_out_item
);
    import mqrf_pkg::*;

    // Store spans every queue back to back: queue q occupies q*QUEUE_DEPTH onwards.
    localparam int STORE_DEPTH = QUEUE_COUNT * QUEUE_DEPTH;
    localparam int AW          = $clog2(STORE_DEPTH);

    logic          w_f_valid;
    logic          w_f_ready;
    t_cmd          w_f_cmd;
    logic [AW-1:0] w_f_addr;

    logic          w_q_valid;
    logic          w_q_ready;
    t_cmd          w_q_cmd;
    logic [AW-1:0] w_q_addr;

    mqrf_front #(
        .QUEUE_COUNT (QUEUE_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_cmd   (w_f_cmd),
        .o_addr  (w_f_addr)
    );

    // Short queue so that front and back stall independently.
    mqrf_cmd_queue #(
        .AW (AW)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_cmd   (w_f_cmd),
        .i_addr  (w_f_addr),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_cmd   (w_q_cmd),
        .o_addr  (w_q_addr)
    );

    mqrf_back #(
        .AW        (AW),
        .DEPTH     (STORE_DEPTH),
        .REF_WIDTH (REF_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_cmd   (w_q_cmd),
        .i_addr  (w_q_addr),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

/* sim/tb_multi_queue_ring_fifo.sv */
// Testbench for the multi-queue ring FIFO: queued request driver, answer monitor, predictor.
module tb_multi_queue_ring_fifo;
    timeunit 1ns;
    timeprecision 1ps;

    import mqrf_pkg::*;

    localparam int Q_COUNT = 16;
    localparam int Q_DEPTH = 32;
    localparam int REF_W   = 32;
    localparam int PTR_W   = $clog2(Q_DEPTH);

    // Operation code the block does not define; answered as a bad request.
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 800;
    // Receiver hold-off long enough to fill the command queue and stall the input.
    localparam int LONG_HOLD    = 150;
    localparam int LONG_HOLD_AT = 200;
    // Slack after the last answer.
    localparam int SETTLE       = 20;
    // Longest correct quiet spell is the long hold or the longest item gap plus a
    // drain wait; several times that.
    localparam int STUCK_LIMIT  = 2000;

    typedef struct {
        t_in_item    req;
        int unsigned gap;        // idle cycles before offering this item
        bit          wait_empty; // hold back until every answer has arrived
    } t_req_slot;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    t_req_slot req_backlog[$];
    t_out_item answers_due[$];

    // Predictor state: per-queue pointers and the shared reference store.
    logic [REF_W-1:0] ref_store [Q_COUNT][Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr [Q_COUNT] = '{default: '0};
    logic [PTR_W-1:0] rd_ptr [Q_COUNT] = '{default: '0};

    int unsigned gap_count      = 0;
    int unsigned planned        = 0;
    int          gap_mode       = 0;
    bit          drain_next     = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned hold_left      = 0;
    bit          long_hold_done = 1'b0;
    int unsigned stuck_cycles   = 0;

    multi_queue_ring_fifo #(
        .QUEUE_COUNT (Q_COUNT),
        .QUEUE_DEPTH (Q_DEPTH),
        .REF_WIDTH   (REF_W)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Applies one request to the predictor state and returns its answer.
    function automatic t_out_item queue_op_answer(input t_in_item req);
        t_out_item        ans;
        int               qi;
        logic [PTR_W-1:0] nxt;
        ans        = '0;
        ans.status = ST_BAD;
        if (req.queue_index < Q_COUNT) begin
            qi  = int'(req.queue_index);
            nxt = wr_ptr[qi] + 1'b1;
            case (req.operation)
                OP_CLEAR: begin
                    wr_ptr[qi]       = '0;
                    rd_ptr[qi]       = '0;
                    ans.status       = ST_OK;
                    ans.echoed_queue = req.queue_index;
                end
                OP_PUSH: begin
                    // one slot stays free: full when the write pointer would catch up
                    if (nxt == rd_ptr[qi]) begin
                        ans.status = ST_FULL;
                    end else begin
                        ref_store[qi][wr_ptr[qi]] = req.message_ref;
                        wr_ptr[qi]                = nxt;
                        ans.status                = ST_OK;
                    end
                end
                OP_POP: begin
                    if (rd_ptr[qi] == wr_ptr[qi]) begin
                        ans.status = ST_EMPTY;
                    end else begin
                        ans.popped_ref = ref_store[qi][rd_ptr[qi]];
                        rd_ptr[qi]     = rd_ptr[qi] + 1'b1;
                        ans.status     = ST_OK;
                    end
                end
                default: ;
            endcase
        end
        return ans;
    endfunction

    // Mostly short gaps, a few long; mode 0 gives back-to-back items.
    function automatic int unsigned pick_gap(input int mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (mode == 0 || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [REF_W-1:0] pick_ref();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return $urandom;
    endfunction

    task automatic add_req(input logic [1:0] op, input int qi, input logic [REF_W-1:0] mref);
        t_req_slot slot;
        slot.req.operation   = op;
        slot.req.queue_index = qi[QIDX_FIELD_W-1:0];
        slot.req.message_ref = mref;
        slot.gap             = pick_gap(gap_mode);
        slot.wait_empty      = drain_next;
        drain_next           = 1'b0;
        req_backlog.push_back(slot);
        planned++;
    endtask

    task automatic build_directed();
        add_req(OP_POP,   0,  32'h1234_5678);   // pop from an empty queue
        add_req(OP_PUSH,  0,  32'h0000_0000);
        add_req(OP_PUSH,  0,  32'hFFFF_FFFF);
        add_req(OP_PUSH,  15, 32'hA5A5_A5A5);
        add_req(OP_POP,   0,  32'hFFFF_FFFF);   // ref ignored on pop
        add_req(OP_POP,   0,  32'h0);
        add_req(OP_POP,   0,  32'h0);           // empty again
        add_req(OP_PUSH,  31, 32'hDEAD_BEEF);   // bad index, nothing stored
        add_req(OP_POP,   16, 32'h0);           // first bad index
        add_req(OP_CLEAR, 16, 32'h0);
        add_req(OP_SPARE, 1,  32'hFFFF_FFFF);   // undefined operation
        add_req(OP_SPARE, 31, 32'h0);
        add_req(OP_CLEAR, 15, 32'hFFFF_FFFF);   // clear drops the pending entry
        add_req(OP_POP,   15, 32'h0);
        add_req(OP_CLEAR, 0,  32'h0);
        add_req(OP_PUSH,  7,  32'h5A5A_5A5A);
        add_req(OP_PUSH,  7,  32'h0F0F_0F0F);
        add_req(OP_POP,   7,  32'h0);
        add_req(OP_CLEAR, 7,  32'h0);           // clear a queue still holding an item
        add_req(OP_POP,   7,  32'h0);
    endtask

    // Runs of pushes or pops on one queue reach full and empty; the rest is
    // mixed traffic on a few hot queues plus clears and bad requests.
    task automatic build_random();
        int unsigned target;
        int          seg;
        int          kind;
        int          qi;
        int          hot_a;
        int          hot_b;
        int          n;
        target = planned + RANDOM_ITEMS;
        seg    = 0;
        while (planned < target) begin
            kind       = (seg == 0) ? 0 : $urandom_range(0, 99);
            gap_mode   = $urandom_range(0, 2);
            drain_next = (seg % 17 == 5);
            qi         = $urandom_range(0, Q_COUNT - 1);
            if (kind < 30) begin
                n = $urandom_range(25, 36);
                repeat (n) begin
                    if ($urandom_range(0, 9) == 0) begin
                        add_req(OP_POP, qi, pick_ref());
                    end else begin
                        add_req(OP_PUSH, qi, pick_ref());
                    end
                end
            end else if (kind < 55) begin
                n = $urandom_range(20, 36);
                repeat (n) add_req(OP_POP, qi, pick_ref());
            end else if (kind < 80) begin
                hot_a = $urandom_range(0, Q_COUNT - 1);
                hot_b = $urandom_range(0, Q_COUNT - 1);
                repeat (20) begin
                    qi = $urandom_range(0, 1) ? hot_a : hot_b;
                    if ($urandom_range(0, 99) < 55) begin
                        add_req(OP_PUSH, qi, pick_ref());
                    end else begin
                        add_req(OP_POP, qi, pick_ref());
                    end
                end
            end else if (kind < 90) begin
                add_req(OP_CLEAR, qi, pick_ref());
                n = $urandom_range(0, 2);
                repeat (n) add_req(OP_POP, qi, pick_ref());
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    if ($urandom_range(0, 1)) begin
                        add_req(2'($urandom_range(0, 3)), $urandom_range(Q_COUNT, 31),
                                pick_ref());
                    end else begin
                        add_req(OP_SPARE, $urandom_range(0, 31), pick_ref());
                    end
                end
            end
            seg++;
        end
    endtask

    // Driver: offers backlog items, holding each until taken; predicts on acceptance.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            gap_count <= 0;
        end else begin
            if (in_valid && in_ready) begin
                answers_due.push_back(queue_op_answer(in_item));
            end
            if (!in_valid || in_ready) begin
                if (req_backlog.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (gap_count < req_backlog[0].gap) begin
                    in_valid  <= 1'b0;
                    gap_count <= gap_count + 1;
                end else if (req_backlog[0].wait_empty && answers_due.size() != 0) begin
                    // sender pause: let every outstanding answer come back first
                    in_valid <= 1'b0;
                end else begin
                    in_item   <= req_backlog[0].req;
                    in_valid  <= 1'b1;
                    gap_count <= 0;
                    void'(req_backlog.pop_front());
                end
            end
        end
    end

    // Monitor: checks each answer against the oldest prediction, drives out_ready.
    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (answers_due.size() == 0) begin
                    $error("answer with no request outstanding: status %0d", out_item.status);
                    mismatch_count++;
                end else begin
                    want = answers_due.pop_front();
                    if (out_item.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_item.status);
                        mismatch_count++;
                    end
                    if (out_item.popped_ref !== want.popped_ref) begin
                        $error("popped_ref: expected %h, got %h",
                               want.popped_ref, out_item.popped_ref);
                        mismatch_count++;
                    end
                    if (out_item.echoed_queue !== want.echoed_queue) begin
                        $error("echoed_queue: expected %0d, got %0d",
                               want.echoed_queue, out_item.echoed_queue);
                        mismatch_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
                // one long hold-off while the driver keeps offering
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                hold_left = LONG_HOLD - 1;
            end else if ((results_seen / 64) % 3 != 0 && $urandom_range(0, 99) < 20) begin
                out_ready <= 1'b0;
                hold_left = pick_gap(1);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any handshake on either side.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        build_directed();
        build_random();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        do @(posedge clk); while (req_backlog.size() != 0 || in_valid);
        while (answers_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
